### rtl/display_test_pattern_pixel_top_macros.svh
// ----------------------------------------------------------------------------
// display test pattern pixel - assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef DISPLAY_TEST_PATTERN_PIXEL_TOP_MACROS_SVH
`define DISPLAY_TEST_PATTERN_PIXEL_TOP_MACROS_SVH

// same-cycle implication
`define DTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// types and constants of the display test pattern pixel block
// ----------------------------------------------------------------------------
package dtp_pkg;

  localparam int FW_BITS  = 12;
  localparam int FH_BITS  = 12;
  localparam int LB_BITS  = 14;
  localparam int FMT_BITS = 2;
  localparam int CFG_DATA_BITS = 14;
  localparam int CFG_IDX_BITS  = 2;

  localparam int COLOR_BITS  = 24;
  localparam int WORD_BITS   = 24;
  localparam int OFFSET_BITS = 26;
  localparam int OUT_FIELDS_BITS = COLOR_BITS + WORD_BITS + OFFSET_BITS;
  localparam int OUT_DATA_BITS   = ((OUT_FIELDS_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_LINE_BYTES   = 2'd2,
    CFG_PIXEL_FORMAT = 2'd3
  } cfg_idx_t;

  typedef enum logic [FMT_BITS-1:0] {
    FMT_8BPP   = 2'd0,
    FMT_RGB565 = 2'd1,
    FMT_32BPP  = 2'd2
  } pix_fmt_t;

  localparam logic [FW_BITS-1:0]  FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_BITS-1:0]  FRAME_HEIGHT_RST = 12'd480;
  localparam logic [LB_BITS-1:0]  LINE_BYTES_RST   = 14'd2560;
  localparam logic [FMT_BITS-1:0] PIXEL_FORMAT_RST = FMT_32BPP;

  localparam logic [COLOR_BITS-1:0] COL_WHITE   = 24'hffffff;
  localparam logic [COLOR_BITS-1:0] COL_BLUE    = 24'h0000ff;
  localparam logic [COLOR_BITS-1:0] COL_GREEN   = 24'h00ff00;
  localparam logic [COLOR_BITS-1:0] COL_RED     = 24'hff0000;
  localparam logic [COLOR_BITS-1:0] COL_YELLOW  = 24'hffff00;
  localparam logic [COLOR_BITS-1:0] COL_MAGENTA = 24'hff00ff;
  localparam logic [COLOR_BITS-1:0] COL_CYAN    = 24'h00ffff;
  localparam logic [COLOR_BITS-1:0] COL_BLACK   = 24'h000000;

endpackage

### rtl/display_test_pattern_pixel_top.sv
// ----------------------------------------------------------------------------
// display_test_pattern_pixel_top
// test pattern colour, packed pixel word and frame buffer byte offset
// for one pixel coordinate per transaction
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | tdata: pixel_x, pixel_y
//  out_    | out | tdata: color_rgb, pixel_word, byte_offset; tuser: in_frame
//  cfg_    | in  | frame_width, frame_height, line_bytes, pixel_format
//
//  one transaction per cycle sustained while out_tready is high; an accepted
//  input reaches result valid through the input register, then the result register
//  the path between them is one 14x12 multiply-add and the pattern compares
//  a stalled result holds in the result register while the input register
//  still takes one more coordinate
//  rst_n synchronous: empties both stages and loads register defaults
// ----------------------------------------------------------------------------
`include "display_test_pattern_pixel_top_macros.svh"

module display_test_pattern_pixel_top #(
  parameter int COORD_BITS = 12,
  parameter int BAR_WIDTH  = 20
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: pixel_x, pixel_y
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  // out_tdata: color_rgb, pixel_word, byte_offset
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [dtp_pkg::OUT_DATA_BITS-1:0]      out_tdata,
  // out_tuser: in_frame
  output logic                                   out_tuser,
  input  logic                                   cfg_wr_en,
  input  logic [dtp_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [dtp_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);
  import dtp_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int SW = ((COORD_BITS > 7) ? COORD_BITS : 7) + 3;
  localparam logic signed [SW-1:0] BAR = SW'(BAR_WIDTH);

  // configuration registers
  logic [FW_BITS-1:0]  frame_width_r;
  logic [FH_BITS-1:0]  frame_height_r;
  logic [LB_BITS-1:0]  line_bytes_r;
  logic [FMT_BITS-1:0] pixel_format_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      line_bytes_r   <= LINE_BYTES_RST;
      pixel_format_r <= PIXEL_FORMAT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FH_BITS-1:0];
        CFG_LINE_BYTES:   line_bytes_r   <= cfg_wdata[LB_BITS-1:0];
        CFG_PIXEL_FORMAT: pixel_format_r <= cfg_wdata[FMT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic in_valid_r;
  logic out_valid_r;
  logic advance;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // input register
  logic [CW-1:0] x_r;
  logic [CW-1:0] y_r;

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      x_r <= in_tdata[CW-1:0];
      y_r <= in_tdata[2*CW-1:CW];
    end
  end

  // pattern logic
  logic [CW-1:0]        w;
  logic [CW-1:0]        h;
  logic signed [SW-1:0] xs, ys, ws, hs, x3;
  logic                 mid_x, mid_y, frame_hit, rgb565;
  logic [7:0]           lvl32, lvl64;
  logic [COLOR_BITS-1:0]  color;
  logic [WORD_BITS-1:0]   word;
  logic [CW+1:0]          x_bytes;
  logic [CW+LB_BITS-1:0]  row_off;
  logic [OFFSET_BITS-1:0] offset;

  assign w  = CW'(frame_width_r);
  assign h  = CW'(frame_height_r);
  assign xs = $signed(SW'(x_r));
  assign ys = $signed(SW'(y_r));
  assign ws = $signed(SW'(w));
  assign hs = $signed(SW'(h));
  assign x3 = (xs <<< 1) + xs;

  assign frame_hit = (x_r < w) && (y_r < h);
  assign mid_y     = (ys > BAR) && (ys < hs - BAR);
  assign mid_x     = (xs > BAR) && (xs < ws - BAR);
  assign rgb565    = (pixel_format_r == FMT_RGB565);
  assign lvl32     = rgb565 ? {y_r[4:0], 3'b000} : y_r[7:0];
  assign lvl64     = rgb565 ? {y_r[5:0], 2'b00}  : y_r[7:0];

  always_comb begin
    if (xs < BAR && ys < BAR) begin
      color = COL_WHITE;
    end else if (xs < BAR && mid_y) begin
      color = COL_BLUE;
    end else if (ys < BAR && mid_x) begin
      color = COL_GREEN;
    end else if (xs > ws - BAR && mid_y) begin
      color = COL_RED;
    end else if (ys > hs - BAR && mid_x) begin
      color = COL_YELLOW;
    end else if (xs == BAR || xs == ws - BAR || ys == BAR || ys == hs - BAR) begin
      color = COL_WHITE;
    end else if (xs == ys || ws - xs == hs - ys) begin
      color = COL_MAGENTA;
    end else if (ws - xs == ys || xs == hs - ys) begin
      color = COL_CYAN;
    end else if (mid_x && mid_y) begin
      // ramp thirds across the width
      if (x3 < ws) begin
        color = {16'h0000, lvl32};
      end else if (x3 < (ws <<< 1)) begin
        color = {8'h00, lvl64, 8'h00};
      end else begin
        color = {lvl32, 16'h0000};
      end
    end else begin
      color = COL_BLACK;
    end
  end

  always_comb begin
    case (pixel_format_r)
      FMT_8BPP: begin
        word    = {16'h0000, color[7:0]};
        x_bytes = {2'b00, x_r};
      end
      FMT_RGB565: begin
        word    = {8'h00, color[23:19], color[15:10], color[7:3]};
        x_bytes = {1'b0, x_r, 1'b0};
      end
      default: begin
        word    = color;
        x_bytes = {x_r, 2'b00};
      end
    endcase
  end

  assign row_off = y_r * line_bytes_r;
  assign offset  = OFFSET_BITS'(row_off) + OFFSET_BITS'(x_bytes);

  // result register
  logic [COLOR_BITS-1:0]  color_r;
  logic [WORD_BITS-1:0]   word_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic                   in_frame_r;

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      in_frame_r <= frame_hit;
      color_r    <= frame_hit ? color  : '0;
      word_r     <= frame_hit ? word   : '0;
      offset_r   <= frame_hit ? offset : '0;
    end
  end

  assign out_tdata = OUT_DATA_BITS'({offset_r, word_r, color_r});
  assign out_tuser = in_frame_r;

  `DTP_ASSERT_NOW(a_off_frame_zero, out_valid_r && !in_frame_r, out_tdata == '0,
    "result outside the frame carries non-zero data")
  `DTP_ASSERT_NEXT(a_in_hold, in_valid_r && !advance,
    in_valid_r && $stable(x_r) && $stable(y_r), "stalled coordinate lost or changed")
  `DTP_ASSERT_NOW(a_ready_when_empty, !out_valid_r, in_tready,
    "input stalled with an empty result register")
  `DTP_ASSERT_NEXT(a_accept_loads, in_tvalid && in_tready, in_valid_r,
    "accepted transaction not held in the input register")

endmodule
